// ===== rtl/cr3_pkg.sv =====
// ----------------------------------------------------------------------------
// cr3_pkg
// Shared types, widths and helpers for the three-body derivative pipeline.
// ----------------------------------------------------------------------------
package cr3_pkg;

  localparam int XW         = 48;   // state and result field width
  localparam int MW         = 49;   // offset magnitude width
  localparam int R2W        = 100;  // squared distance width
  localparam int MUW        = 32;   // mass ratio register width
  localparam int MU_ALIGN   = 40;   // mass ratio scaling shift base
  localparam int CHUNK_SQ   = 16;   // multiplier digit for the squares
  localparam int CHUNK_WIDE = 8;    // multiplier digit for wide operands
  localparam int TLW        = 61;   // clipped term magnitude width
  localparam int TSW        = 62;   // signed term width
  localparam int SUMW       = 64;   // acceleration sum width

  localparam logic [MUW-1:0]  MU_RESET = 32'd52186368;
  localparam logic [TLW-1:0]  TERM_LIM = 61'h1000_0000_0000_0000;
  localparam logic signed [SUMW-1:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [SUMW-1:0] OUT_MIN = -64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] vx;
    logic signed [XW-1:0] vy;
    logic signed [XW-1:0] vz;
    logic [MW-1:0]        dx1m;
    logic [MW-1:0]        dx2m;
    logic [MW-1:0]        ym;
    logic [MW-1:0]        zm;
    logic                 dx1n;
    logic                 dx2n;
    logic                 yn;
    logic                 zn;
  } side_t;

  typedef struct packed {
    side_t side;
    logic  big1;
    logic  big2;
  } tm_tag_t;

  // {clipped, value}
  function automatic logic [XW:0] clip48(input logic signed [SUMW-1:0] s);
    logic [XW:0] res;
    if (s > OUT_MAX) begin
      res = {1'b1, OUT_MAX[XW-1:0]};
    end else if (s < OUT_MIN) begin
      res = {1'b1, OUT_MIN[XW-1:0]};
    end else begin
      res = {1'b0, s[XW-1:0]};
    end
    return res;
  endfunction

endpackage

// ===== rtl/cr3_mul.sv =====
// ----------------------------------------------------------------------------
// cr3_mul
// Pipelined unsigned multiplier, one CW-bit digit of b per stage, with a tag.
// ----------------------------------------------------------------------------
module cr3_mul #(
  parameter int AW = 49,
  parameter int BW = 49,
  parameter int CW = 16,
  parameter int TW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             v_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  input  logic [TW-1:0]    t_i,
  output logic             v_o,
  output logic [AW+BW-1:0] p_o,
  output logic [TW-1:0]    t_o
);

  localparam int NS = (BW + CW - 1) / CW;
  localparam int BP = NS * CW;
  localparam int EW = AW + BP;

  logic          v_r   [NS];
  logic [AW-1:0] a_r   [NS];
  logic [BP-1:0] b_r   [NS];
  logic [EW-1:0] acc_r [NS];
  logic [TW-1:0] t_r   [NS];

  logic          v_nxt   [NS];
  logic [AW-1:0] a_nxt   [NS];
  logic [BP-1:0] b_nxt   [NS];
  logic [EW-1:0] acc_nxt [NS];
  logic [TW-1:0] t_nxt   [NS];

  always_comb begin
    logic [EW-1:0]    acc_prev;
    logic [AW+CW-1:0] pp;
    for (int j = 0; j < NS; j++) begin
      if (j == 0) begin
        v_nxt[j] = v_i;
        a_nxt[j] = a_i;
        b_nxt[j] = BP'(b_i);
        t_nxt[j] = t_i;
        acc_prev = '0;
      end else begin
        v_nxt[j] = v_r[j-1];
        a_nxt[j] = a_r[j-1];
        b_nxt[j] = b_r[j-1];
        t_nxt[j] = t_r[j-1];
        acc_prev = acc_r[j-1];
      end
      pp = {{CW{1'b0}}, a_nxt[j]} * {{AW{1'b0}}, b_nxt[j][j*CW +: CW]};
      acc_nxt[j] = acc_prev + (EW'(pp) << (j * CW));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NS; j++) v_r[j] <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    t_r   <= t_nxt;
  end

  assign v_o = v_r[NS-1];
  assign p_o = acc_r[NS-1][AW+BW-1:0];
  assign t_o = t_r[NS-1];

endmodule

// ===== rtl/cr3_gain.sv =====
// ----------------------------------------------------------------------------
// cr3_gain
// Pull factor m / r^3: pipelined square root, r^2 * r, pipelined divider.
// ----------------------------------------------------------------------------
module cr3_gain #(
  parameter int FRAC_BITS = 32,
  parameter int TW        = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     v_i,
  input  logic [cr3_pkg::R2W-1:0]  r2_i,
  input  logic [FRAC_BITS:0]       m_i,
  input  logic [TW-1:0]            t_i,
  output logic                     v_o,
  output logic [2*FRAC_BITS:0]     k_o,
  output logic                     big_o,
  output logic [TW-1:0]            t_o
);

  localparam int R2W = cr3_pkg::R2W;
  localparam int SW  = R2W / 2;
  localparam int RW  = SW + 3;
  localparam int MQW = FRAC_BITS + 1;
  localparam int NW  = 2 * FRAC_BITS + 1;
  localparam int PW  = R2W + SW;
  localparam int R3W = PW - 2 * FRAC_BITS;

  // square root, one result bit per stage
  logic           sv_r    [SW];
  logic [RW-1:0]  srem_r  [SW];
  logic [SW-1:0]  sroot_r [SW];
  logic [R2W-1:0] sr2_r   [SW];
  logic [MQW-1:0] sm_r    [SW];
  logic [TW-1:0]  st_r    [SW];

  logic           sv_nxt    [SW];
  logic [RW-1:0]  srem_nxt  [SW];
  logic [SW-1:0]  sroot_nxt [SW];
  logic [R2W-1:0] sr2_nxt   [SW];
  logic [MQW-1:0] sm_nxt    [SW];
  logic [TW-1:0]  st_nxt    [SW];

  always_comb begin
    logic [RW-1:0] rem_src;
    logic [SW-1:0] root_src;
    logic [RW-1:0] remsh;
    logic [RW-1:0] trial;
    for (int i = 0; i < SW; i++) begin
      if (i == 0) begin
        sv_nxt[i]  = v_i;
        sr2_nxt[i] = r2_i;
        sm_nxt[i]  = m_i;
        st_nxt[i]  = t_i;
        rem_src    = '0;
        root_src   = '0;
      end else begin
        sv_nxt[i]  = sv_r[i-1];
        sr2_nxt[i] = sr2_r[i-1];
        sm_nxt[i]  = sm_r[i-1];
        st_nxt[i]  = st_r[i-1];
        rem_src    = srem_r[i-1];
        root_src   = sroot_r[i-1];
      end
      remsh = {rem_src[RW-3:0], sr2_nxt[i][R2W-1-2*i -: 2]};
      trial = RW'({root_src, 2'b01});
      if (remsh >= trial) begin
        srem_nxt[i]  = remsh - trial;
        sroot_nxt[i] = {root_src[SW-2:0], 1'b1};
      end else begin
        srem_nxt[i]  = remsh;
        sroot_nxt[i] = {root_src[SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SW; i++) sv_r[i] <= 1'b0;
    end else begin
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    srem_r  <= srem_nxt;
    sroot_r <= sroot_nxt;
    sr2_r   <= sr2_nxt;
    sm_r    <= sm_nxt;
    st_r    <= st_nxt;
  end

  // r^2 * r
  logic              mv;
  logic [PW-1:0]     mp;
  logic [TW+MQW-1:0] mt;

  cr3_mul #(
    .AW(R2W),
    .BW(SW),
    .CW(cr3_pkg::CHUNK_WIDE),
    .TW(TW + MQW)
  ) u_cube (
    .clk  (clk),
    .rst_n(rst_n),
    .v_i  (sv_r[SW-1]),
    .a_i  (sr2_r[SW-1]),
    .b_i  (sroot_r[SW-1]),
    .t_i  ({st_r[SW-1], sm_r[SW-1]}),
    .v_o  (mv),
    .p_o  (mp),
    .t_o  (mt)
  );

  logic           cv_r;
  logic [R3W-1:0] r3_r;
  logic [MQW-1:0] cm_r;
  logic [TW-1:0]  ct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else begin
      cv_r <= mv;
    end
  end

  always_ff @(posedge clk) begin
    r3_r <= mp[PW-1:2*FRAC_BITS];
    cm_r <= mt[MQW-1:0];
    ct_r <= mt[TW+MQW-1:MQW];
  end

  // restoring divider, one quotient bit per stage
  logic           dv_r   [NW];
  logic [R3W-1:0] drem_r [NW];
  logic [NW-1:0]  dq_r   [NW];
  logic [NW-1:0]  dn_r   [NW];
  logic [R3W-1:0] dd_r   [NW];
  logic           dbig_r [NW];
  logic [TW-1:0]  dt_r   [NW];

  logic           dv_nxt   [NW];
  logic [R3W-1:0] drem_nxt [NW];
  logic [NW-1:0]  dq_nxt   [NW];
  logic [NW-1:0]  dn_nxt   [NW];
  logic [R3W-1:0] dd_nxt   [NW];
  logic           dbig_nxt [NW];
  logic [TW-1:0]  dt_nxt   [NW];

  always_comb begin
    logic [R3W-1:0] rem_src;
    logic [NW-1:0]  q_src;
    logic [NW-1:0]  n_src;
    logic [R3W:0]   remsh;
    logic [R3W:0]   dext;
    for (int j = 0; j < NW; j++) begin
      if (j == 0) begin
        dv_nxt[j]   = cv_r;
        dd_nxt[j]   = r3_r;
        dbig_nxt[j] = (r3_r == '0);
        dt_nxt[j]   = ct_r;
        rem_src     = '0;
        q_src       = '0;
        n_src       = NW'(cm_r) << FRAC_BITS;
      end else begin
        dv_nxt[j]   = dv_r[j-1];
        dd_nxt[j]   = dd_r[j-1];
        dbig_nxt[j] = dbig_r[j-1];
        dt_nxt[j]   = dt_r[j-1];
        rem_src     = drem_r[j-1];
        q_src       = dq_r[j-1];
        n_src       = dn_r[j-1];
      end
      remsh     = {rem_src, n_src[NW-1]};
      dext      = {1'b0, dd_nxt[j]};
      dn_nxt[j] = n_src << 1;
      if (remsh >= dext) begin
        drem_nxt[j] = R3W'(remsh - dext);
        dq_nxt[j]   = {q_src[NW-2:0], 1'b1};
      end else begin
        drem_nxt[j] = remsh[R3W-1:0];
        dq_nxt[j]   = {q_src[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NW; j++) dv_r[j] <= 1'b0;
    end else begin
      dv_r <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drem_r <= drem_nxt;
    dq_r   <= dq_nxt;
    dn_r   <= dn_nxt;
    dd_r   <= dd_nxt;
    dbig_r <= dbig_nxt;
    dt_r   <= dt_nxt;
  end

  assign v_o   = dv_r[NW-1];
  assign k_o   = dq_r[NW-1];
  assign big_o = dbig_r[NW-1];
  assign t_o   = dt_r[NW-1];

endmodule

// ===== rtl/cr3bp_state_derivative_core.sv =====
// ----------------------------------------------------------------------------
// cr3bp_state_derivative_core
// Rotating-frame state derivative under the circular restricted three-body
// model, fully pipelined, saturating.
// ----------------------------------------------------------------------------
//  channel  | ports                          | transaction
//  ---------+--------------------------------+------------------------------
//  input    | start, busy, in_pos_*, in_vel_* | start && !busy
//  result   | out_strobe, out_*              | one cycle per strobe
//  config   | cfg_valid, cfg_ready, cfg_*    | cfg_valid && cfg_ready
//
//  One state accepted per cycle; busy stays low.
//  The deepest parts of the pipeline are the 50-stage square root and the
//  (2*FRAC_BITS+1)-stage divider in each pull-factor unit.
//  Synchronous active-low reset clears the valid bits and loads mass_ratio.
//  Results cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module cr3bp_state_derivative_core #(
  parameter int FRAC_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [cr3_pkg::XW-1:0]      in_pos_x,
  input  logic signed [cr3_pkg::XW-1:0]      in_pos_y,
  input  logic signed [cr3_pkg::XW-1:0]      in_pos_z,
  input  logic signed [cr3_pkg::XW-1:0]      in_vel_x,
  input  logic signed [cr3_pkg::XW-1:0]      in_vel_y,
  input  logic signed [cr3_pkg::XW-1:0]      in_vel_z,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cr3_pkg::MUW-1:0]            cfg_mass_ratio,
  output logic                               out_strobe,
  output logic signed [cr3_pkg::XW-1:0]      out_dpos_x,
  output logic signed [cr3_pkg::XW-1:0]      out_dpos_y,
  output logic signed [cr3_pkg::XW-1:0]      out_dpos_z,
  output logic signed [cr3_pkg::XW-1:0]      out_accel_x,
  output logic signed [cr3_pkg::XW-1:0]      out_accel_y,
  output logic signed [cr3_pkg::XW-1:0]      out_accel_z,
  output logic                               out_saturated
);

  localparam int XW   = cr3_pkg::XW;
  localparam int MW   = cr3_pkg::MW;
  localparam int R2W  = cr3_pkg::R2W;
  localparam int MQW  = FRAC_BITS + 1;
  localparam int NW   = 2 * FRAC_BITS + 1;
  localparam int PRW  = NW + MW;
  localparam int PMW  = PRW - FRAC_BITS;
  localparam int TLW  = cr3_pkg::TLW;
  localparam int TSW  = cr3_pkg::TSW;
  localparam int SUMW = cr3_pkg::SUMW;

  typedef struct packed {
    logic [MQW-1:0]  m1;
    logic [MQW-1:0]  mu;
    cr3_pkg::side_t  side;
  } sq_tag_t;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic [cr3_pkg::MUW-1:0] mass_ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_ratio_r <= cr3_pkg::MU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mass_ratio_r <= cfg_mass_ratio;
    end
  end

  // stage 1: offsets and magnitudes
  logic [cr3_pkg::MUW+7:0] mu_w;
  logic [MQW-1:0]          mu_q;
  logic [MQW-1:0]          m1_q;
  logic [MW-1:0]           xe, ye, ze, dx1, dx2;
  cr3_pkg::side_t          side_nxt;

  always_comb begin
    mu_w = {mass_ratio_r, 8'd0};
    mu_q = MQW'(mu_w >> (cr3_pkg::MU_ALIGN - FRAC_BITS));
    m1_q = (MQW'(1) << FRAC_BITS) - mu_q;
    xe   = {in_pos_x[XW-1], in_pos_x};
    ye   = {in_pos_y[XW-1], in_pos_y};
    ze   = {in_pos_z[XW-1], in_pos_z};
    dx1  = xe + MW'(mu_q);
    dx2  = xe - MW'(m1_q);
    side_nxt.x    = in_pos_x;
    side_nxt.y    = in_pos_y;
    side_nxt.vx   = in_vel_x;
    side_nxt.vy   = in_vel_y;
    side_nxt.vz   = in_vel_z;
    side_nxt.dx1n = dx1[MW-1];
    side_nxt.dx2n = dx2[MW-1];
    side_nxt.yn   = ye[MW-1];
    side_nxt.zn   = ze[MW-1];
    side_nxt.dx1m = dx1[MW-1] ? -dx1 : dx1;
    side_nxt.dx2m = dx2[MW-1] ? -dx2 : dx2;
    side_nxt.ym   = ye[MW-1] ? -ye : ye;
    side_nxt.zm   = ze[MW-1] ? -ze : ze;
  end

  logic    s1_v_r;
  sq_tag_t s1_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag_r <= '{m1: m1_q, mu: mu_q, side: side_nxt};
  end

  // stage 2: squares (dx1, dx2, y, z)
  logic [MW-1:0]          sq_a   [4];
  logic [2*MW-1:0]        sq_p   [4];
  logic                   sq_v   [4];
  logic [$bits(sq_tag_t)-1:0] sq_t [4];
  sq_tag_t                sq_tag;

  assign sq_a[0] = s1_tag_r.side.dx1m;
  assign sq_a[1] = s1_tag_r.side.dx2m;
  assign sq_a[2] = s1_tag_r.side.ym;
  assign sq_a[3] = s1_tag_r.side.zm;

  for (genvar g = 0; g < 4; g++) begin : g_sq
    cr3_mul #(
      .AW(MW),
      .BW(MW),
      .CW(cr3_pkg::CHUNK_SQ),
      .TW($bits(sq_tag_t))
    ) u_sq (
      .clk  (clk),
      .rst_n(rst_n),
      .v_i  (s1_v_r),
      .a_i  (sq_a[g]),
      .b_i  (sq_a[g]),
      .t_i  (s1_tag_r),
      .v_o  (sq_v[g]),
      .p_o  (sq_p[g]),
      .t_o  (sq_t[g])
    );
  end

  assign sq_tag = sq_t[0];

  // stage 3: r^2 for both bodies
  logic           s3_v_r;
  logic [R2W-1:0] r2a_r, r2b_r;
  sq_tag_t        s3_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= sq_v[0];
    end
  end

  always_ff @(posedge clk) begin
    r2a_r    <= R2W'(sq_p[0]) + R2W'(sq_p[2]) + R2W'(sq_p[3]);
    r2b_r    <= R2W'(sq_p[1]) + R2W'(sq_p[2]) + R2W'(sq_p[3]);
    s3_tag_r <= sq_tag;
  end

  // pull factors
  logic           g1_v, g2_v, g1_big, g2_big;
  logic [NW-1:0]  g1_k, g2_k;
  cr3_pkg::side_t g_side;

  cr3_gain #(
    .FRAC_BITS(FRAC_BITS),
    .TW($bits(cr3_pkg::side_t))
  ) u_gain1 (
    .clk  (clk),
    .rst_n(rst_n),
    .v_i  (s3_v_r),
    .r2_i (r2a_r),
    .m_i  (s3_tag_r.m1),
    .t_i  (s3_tag_r.side),
    .v_o  (g1_v),
    .k_o  (g1_k),
    .big_o(g1_big),
    .t_o  (g_side)
  );

  cr3_gain #(
    .FRAC_BITS(FRAC_BITS),
    .TW(1)
  ) u_gain2 (
    .clk  (clk),
    .rst_n(rst_n),
    .v_i  (s3_v_r),
    .r2_i (r2b_r),
    .m_i  (s3_tag_r.mu),
    .t_i  (1'b0),
    .v_o  (g2_v),
    .k_o  (g2_k),
    .big_o(g2_big),
    .t_o  ()
  );

  // products k * |offset|
  cr3_pkg::tm_tag_t g_tag;
  logic [NW-1:0]    pk  [6];
  logic [MW-1:0]    pv  [6];
  logic [PRW-1:0]   pr  [6];
  logic             pr_v [6];
  logic [$bits(cr3_pkg::tm_tag_t)-1:0] pr_t [6];
  cr3_pkg::tm_tag_t p_tag;

  assign g_tag = '{side: g_side, big1: g1_big, big2: g2_big};
  assign pk[0] = g1_k;
  assign pk[1] = g1_k;
  assign pk[2] = g1_k;
  assign pk[3] = g2_k;
  assign pk[4] = g2_k;
  assign pk[5] = g2_k;
  assign pv[0] = g_side.dx1m;
  assign pv[1] = g_side.ym;
  assign pv[2] = g_side.zm;
  assign pv[3] = g_side.dx2m;
  assign pv[4] = g_side.ym;
  assign pv[5] = g_side.zm;

  for (genvar g = 0; g < 6; g++) begin : g_term
    cr3_mul #(
      .AW(NW),
      .BW(MW),
      .CW(cr3_pkg::CHUNK_WIDE),
      .TW($bits(cr3_pkg::tm_tag_t))
    ) u_term (
      .clk  (clk),
      .rst_n(rst_n),
      .v_i  (g1_v),
      .a_i  (pk[g]),
      .b_i  (pv[g]),
      .t_i  (g_tag),
      .v_o  (pr_v[g]),
      .p_o  (pr[g]),
      .t_o  (pr_t[g])
    );
  end

  assign p_tag = pr_t[0];

  // term stage: truncate, clip, sign
  logic signed [TSW-1:0] tm_nxt [6];
  logic                  tsat_nxt;
  logic                  tm_v_r;
  logic signed [TSW-1:0] tm_r [6];
  logic                  tm_sat_r;
  cr3_pkg::side_t        tm_side_r;

  always_comb begin
    logic [PMW-1:0] pm;
    logic [TLW-1:0] tmag;
    logic           neg, nz, big, clip;
    tsat_nxt = p_tag.big1 | p_tag.big2;
    for (int j = 0; j < 6; j++) begin
      pm  = pr[j][PRW-1:FRAC_BITS];
      big = (j < 3) ? p_tag.big1 : p_tag.big2;
      case (j)
        0:       begin neg = p_tag.side.dx1n; nz = (p_tag.side.dx1m != '0); end
        3:       begin neg = p_tag.side.dx2n; nz = (p_tag.side.dx2m != '0); end
        1, 4:    begin neg = p_tag.side.yn;   nz = (p_tag.side.ym != '0);   end
        default: begin neg = p_tag.side.zn;   nz = (p_tag.side.zm != '0);   end
      endcase
      clip = big ? nz : (pm > PMW'(cr3_pkg::TERM_LIM));
      if (clip) begin
        tmag = cr3_pkg::TERM_LIM;
      end else if (big) begin
        tmag = '0;
      end else begin
        tmag = pm[TLW-1:0];
      end
      tsat_nxt  = tsat_nxt | clip;
      tm_nxt[j] = neg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tm_v_r <= 1'b0;
    end else begin
      tm_v_r <= pr_v[0];
    end
  end

  always_ff @(posedge clk) begin
    tm_r      <= tm_nxt;
    tm_sat_r  <= tsat_nxt;
    tm_side_r <= p_tag.side;
  end

  // final stage: sums and output clip
  logic signed [SUMW-1:0] ax, ay, az;
  logic [XW:0]            cx, cy, cz;

  always_comb begin
    ax = SUMW'(tm_side_r.x) - SUMW'(tm_r[0]) - SUMW'(tm_r[3]) + (SUMW'(tm_side_r.vy) <<< 1);
    ay = SUMW'(tm_side_r.y) - SUMW'(tm_r[1]) - SUMW'(tm_r[4]) - (SUMW'(tm_side_r.vx) <<< 1);
    az = -SUMW'(tm_r[2]) - SUMW'(tm_r[5]);
    cx = cr3_pkg::clip48(ax);
    cy = cr3_pkg::clip48(ay);
    cz = cr3_pkg::clip48(az);
  end

  logic                 out_strobe_r;
  logic signed [XW-1:0] out_dpos_x_r, out_dpos_y_r, out_dpos_z_r;
  logic signed [XW-1:0] out_accel_x_r, out_accel_y_r, out_accel_z_r;
  logic                 out_saturated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= tm_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_dpos_x_r    <= tm_side_r.vx;
    out_dpos_y_r    <= tm_side_r.vy;
    out_dpos_z_r    <= tm_side_r.vz;
    out_accel_x_r   <= cx[XW-1:0];
    out_accel_y_r   <= cy[XW-1:0];
    out_accel_z_r   <= cz[XW-1:0];
    out_saturated_r <= tm_sat_r | cx[XW] | cy[XW] | cz[XW];
  end

  assign out_strobe    = out_strobe_r;
  assign out_dpos_x    = out_dpos_x_r;
  assign out_dpos_y    = out_dpos_y_r;
  assign out_dpos_z    = out_dpos_z_r;
  assign out_accel_x   = out_accel_x_r;
  assign out_accel_y   = out_accel_y_r;
  assign out_accel_z   = out_accel_z_r;
  assign out_saturated = out_saturated_r;

`ifndef SYNTHESIS
  a_gain_lockstep: assert property (@(posedge clk) disable iff (!rst_n) g1_v == g2_v)
    else $error("pull-factor units out of step");

  a_term_sat: assert property (@(posedge clk) disable iff (!rst_n)
    tm_v_r && tm_sat_r |=> out_strobe && out_saturated)
    else $error("term clip lost before output");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe after reset");
`endif

endmodule
